// ----- hw/rtl/tlvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and constants for the validating record parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

    // record limits
    localparam int MAX_RECORD_BYTES = 65536;
    localparam int MAX_FIELDS       = 64;
    localparam int KNOWN_SLOTS      = 8;
    localparam int BC_W             = $clog2(MAX_RECORD_BYTES + 2);

    // fixed record bytes
    localparam logic [7:0] SCHEMA_BYTE  = 8'd3;
    localparam logic [7:0] CRITICAL_BIT = 8'h01;

    // configuration register indexes
    localparam logic CFG_EXPECTED_KIND = 1'b0;
    localparam logic CFG_KNOWN_IDS     = 1'b1;

    // result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SIZE      = 4'd1;
    localparam logic [3:0] ST_SCHEMA    = 4'd2;
    localparam logic [3:0] ST_COUNT     = 4'd3;
    localparam logic [3:0] ST_TRUNC_HDR = 4'd4;
    localparam logic [3:0] ST_FLAGS     = 4'd5;
    localparam logic [3:0] ST_TRUNC_VAL = 4'd6;
    localparam logic [3:0] ST_UNKNOWN   = 4'd7;
    localparam logic [3:0] ST_TRAILING  = 4'd8;

    // one result item
    typedef struct packed {
        logic       result_kind;
        logic [7:0] field_id;
        logic       critical;
        logic [7:0] value_byte;
        logic       field_end;
        logic [3:0] status;
        logic       last_of_run;
    } t_result;

endpackage

// ----- hw/rtl/tlv_record_validating_parser_core.sv -----
// ----------------------------------------------------------------------------
// tlv_record_validating_parser_core
// Streaming validating parser for typed, length-prefixed records.
// ----------------------------------------------------------------------------
// One record byte is taken per cycle whenever o_stall is low; each byte is
// parsed in the cycle it is accepted and its results (a value byte, and on
// the last byte a status item) go into a four-entry output queue, from
// which results leave at one item per cycle while i_stall is low. o_stall rises
// only while fewer than two queue entries are free. Value items are
// speculative until the record's status item; configuration writes must be
// made while no record is in progress.
module tlv_record_validating_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_field_id,
    output logic        o_critical,
    output logic [7:0]  o_value_byte,
    output logic        o_field_end,
    output logic [3:0]  o_status,
    output logic        o_last_of_run
);
    import tlvp_pkg::*;

    logic       accept;
    logic       full2;
    t_result    res0;
    t_result    res1;
    t_result    out_res;
    logic [1:0] res_count;
    logic [1:0] push_count;

    assign o_stall    = full2;
    assign accept     = i_valid & ~full2;
    assign push_count = accept ? res_count : 2'd0;

    // byte parser
    tlvp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_res_count (res_count)
    );

    // result queue
    tlvp_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res0       (res0),
        .i_res1       (res1),
        .i_push_count (push_count),
        .i_pop        (~i_stall),
        .o_full2      (full2),
        .o_valid      (o_valid),
        .o_res        (out_res)
    );

    assign o_result_kind = out_res.result_kind;
    assign o_field_id    = out_res.field_id;
    assign o_critical    = out_res.critical;
    assign o_value_byte  = out_res.value_byte;
    assign o_field_end   = out_res.field_end;
    assign o_status      = out_res.status;
    assign o_last_of_run = out_res.last_of_run;

endmodule

// ----- hw/rtl/tlvp_parse.sv -----
// ----------------------------------------------------------------------------
// tlvp_parse
// Per-byte record parser: phase state, counters and checks, producing up to
// two result items for each accepted byte.
// ----------------------------------------------------------------------------
module tlvp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output tlvp_pkg::t_result  o_res0,
    output tlvp_pkg::t_result  o_res1,
    output logic [1:0]         o_res_count
);
    import tlvp_pkg::*;

    typedef enum logic [3:0] {
        PH_SCHEMA, PH_KIND, PH_CNT_HI, PH_CNT_LO, PH_FLAGS, PH_ID,
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_VALUE, PH_DONE, PH_DRAIN
    } t_phase;

    localparam logic [BC_W-1:0] BC_MAX = BC_W'(MAX_RECORD_BYTES);

    // configuration registers
    logic [7:0]  r_expected_kind;
    logic [63:0] r_known_ids;

    // parser state
    t_phase          r_phase,          n_phase;
    logic [BC_W-1:0] r_byte_count,     n_byte_count;
    logic [15:0]     r_fields_left,    n_fields_left;
    logic [7:0]      r_previous_id,    n_previous_id;
    logic [7:0]      r_current_id,     n_current_id;
    logic            r_current_crit,   n_current_crit;
    logic [31:0]     r_length_or_left, n_length_or_left;
    logic [3:0]      r_first_error,    n_first_error;
    logic            r_pending_unk,    n_pending_unk;
    logic            r_header_bad,     n_header_bad;

    logic        id_known;
    logic [31:0] len_full;
    logic [15:0] fields_dec;
    logic [3:0]  fail_code;
    logic        do_finish;
    logic        finish_pending;
    logic [3:0]  rec_status;
    t_result     status_res;

    // known-id match across all slots
    always_comb begin
        id_known = 1'b0;
        for (int s = 0; s < KNOWN_SLOTS; s++) begin
            if (r_known_ids[8*s +: 8] != 8'd0 && r_known_ids[8*s +: 8] == r_current_id) begin
                id_known = 1'b1;
            end
        end
    end

    assign len_full   = {r_length_or_left[23:0], i_data_byte};
    assign fields_dec = r_fields_left - 16'd1;

    // next-state and result logic for one byte
    always_comb begin
        n_phase          = r_phase;
        n_fields_left    = r_fields_left;
        n_previous_id    = r_previous_id;
        n_current_id     = r_current_id;
        n_current_crit   = r_current_crit;
        n_length_or_left = r_length_or_left;
        n_first_error    = r_first_error;
        n_pending_unk    = r_pending_unk;
        n_header_bad     = r_header_bad;
        fail_code        = ST_OK;
        do_finish        = 1'b0;
        finish_pending   = r_pending_unk;
        o_res0           = '0;
        o_res1           = '0;
        o_res_count      = 2'd0;
        rec_status       = ST_OK;
        status_res       = '0;

        n_byte_count = (r_byte_count <= BC_MAX) ? r_byte_count + BC_W'(1) : r_byte_count;

        case (r_phase)
            PH_SCHEMA: begin
                if (i_data_byte != SCHEMA_BYTE) fail_code = ST_SCHEMA;
                else n_phase = PH_KIND;
            end
            PH_KIND: begin
                if (i_data_byte != r_expected_kind) fail_code = ST_SCHEMA;
                else n_phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                n_fields_left = {i_data_byte, 8'd0};
                n_phase       = PH_CNT_LO;
            end
            PH_CNT_LO: begin
                n_fields_left = {r_fields_left[15:8], i_data_byte};
                if (n_fields_left > 16'(MAX_FIELDS)) fail_code = ST_COUNT;
                else n_phase = (n_fields_left != 16'd0) ? PH_FLAGS : PH_DONE;
            end
            PH_FLAGS: begin
                n_current_crit = |(i_data_byte & CRITICAL_BIT);
                n_header_bad   = |(i_data_byte & ~CRITICAL_BIT);
                n_phase        = PH_ID;
            end
            PH_ID: begin
                n_current_id = i_data_byte;
                if (i_data_byte == 8'd0 || i_data_byte <= r_previous_id) n_header_bad = 1'b1;
                n_phase = PH_LEN0;
            end
            PH_LEN0: begin
                n_length_or_left = {24'd0, i_data_byte};
                n_phase          = PH_LEN1;
            end
            PH_LEN1: begin
                n_length_or_left = len_full;
                n_phase          = PH_LEN2;
            end
            PH_LEN2: begin
                n_length_or_left = len_full;
                n_phase          = PH_LEN3;
            end
            PH_LEN3: begin
                n_length_or_left = len_full;
                if (r_header_bad) begin
                    fail_code = ST_FLAGS;
                end else begin
                    n_previous_id = r_current_id;
                    n_pending_unk = r_current_crit & ~id_known;
                    if (len_full == 32'd0) begin
                        do_finish      = 1'b1;
                        finish_pending = n_pending_unk;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                o_res0.result_kind = KIND_VALUE;
                o_res0.field_id    = r_current_id;
                o_res0.critical    = r_current_crit;
                o_res0.value_byte  = i_data_byte;
                o_res0.field_end   = (r_length_or_left == 32'd1);
                o_res_count        = 2'd1;
                n_length_or_left   = r_length_or_left - 32'd1;
                if (r_length_or_left == 32'd1) do_finish = 1'b1;
            end
            PH_DONE: begin
                fail_code = ST_TRAILING;
            end
            default: begin
            end
        endcase

        // end of a field's value
        if (do_finish) begin
            if (finish_pending) begin
                fail_code = ST_UNKNOWN;
            end else begin
                n_fields_left = fields_dec;
                n_phase       = (fields_dec != 16'd0) ? PH_FLAGS : PH_DONE;
            end
        end

        // first stream error wins, then drain to the last byte
        if (fail_code != ST_OK) begin
            if (r_first_error == ST_OK) n_first_error = fail_code;
            n_phase = PH_DRAIN;
        end

        // record status on the last byte, size first
        if (n_byte_count < BC_W'(4) || n_byte_count > BC_MAX) rec_status = ST_SIZE;
        else if (n_first_error != ST_OK) rec_status = n_first_error;
        else if (n_phase == PH_DONE) rec_status = ST_OK;
        else if (n_phase == PH_VALUE) rec_status = ST_TRUNC_VAL;
        else rec_status = ST_TRUNC_HDR;

        status_res.result_kind = KIND_STATUS;
        status_res.status      = rec_status;
        status_res.last_of_run = 1'b1;

        if (i_last_byte) begin
            if (o_res_count == 2'd0) begin
                o_res0      = status_res;
                o_res_count = 2'd1;
            end else begin
                o_res1      = status_res;
                o_res_count = 2'd2;
            end
            n_phase          = PH_SCHEMA;
            n_byte_count     = '0;
            n_fields_left    = '0;
            n_previous_id    = '0;
            n_current_id     = '0;
            n_current_crit   = 1'b0;
            n_length_or_left = '0;
            n_first_error    = ST_OK;
            n_pending_unk    = 1'b0;
            n_header_bad     = 1'b0;
        end else if (o_res_count == 2'd1) begin
            o_res0.last_of_run = 1'b1;
        end
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_kind  <= '0;
            r_known_ids      <= '0;
            r_phase          <= PH_SCHEMA;
            r_byte_count     <= '0;
            r_fields_left    <= '0;
            r_previous_id    <= '0;
            r_current_id     <= '0;
            r_current_crit   <= 1'b0;
            r_length_or_left <= '0;
            r_first_error    <= ST_OK;
            r_pending_unk    <= 1'b0;
            r_header_bad     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPECTED_KIND: r_expected_kind <= i_cfg_data[7:0];
                    CFG_KNOWN_IDS:     r_known_ids     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_phase          <= n_phase;
                r_byte_count     <= n_byte_count;
                r_fields_left    <= n_fields_left;
                r_previous_id    <= n_previous_id;
                r_current_id     <= n_current_id;
                r_current_crit   <= n_current_crit;
                r_length_or_left <= n_length_or_left;
                r_first_error    <= n_first_error;
                r_pending_unk    <= n_pending_unk;
                r_header_bad     <= n_header_bad;
            end
        end
    end

endmodule

// ----- hw/rtl/tlvp_outq.sv -----
// ----------------------------------------------------------------------------
// tlvp_outq
// Four-entry result queue: takes up to two items a cycle, gives one while i_pop is high.
// ----------------------------------------------------------------------------
module tlvp_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlvp_pkg::t_result  i_res0,
    input  tlvp_pkg::t_result  i_res1,
    input  logic [1:0]         i_push_count,
    input  logic               i_pop,
    output logic               o_full2,
    output logic               o_valid,
    output tlvp_pkg::t_result  o_res
);
    import tlvp_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop_ok;

    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop & o_valid;
    // room for two more items is needed before another byte is taken
    assign o_full2 = (r_count > 3'd2);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wr_ptr] <= i_res0;
        if (i_push_count == 2'd2) r_mem[r_wr_ptr + 2'd1] <= i_res1;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_count;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop_ok};
            r_count  <= r_count + {1'b0, i_push_count} - {2'b0, pop_ok};
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the validating record parser. Record bytes are fed
// through the valid/stall input channel; every accepted byte runs through a
// behavioural model of the parser, and the value and status items it implies
// are queued and compared field by field with what leaves the output channel.
// A short table of directed records comes first, then random records, mostly
// well formed with random content, under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import tlvp_pkg::*;

    // generous: several times the slowest legal run
    localparam int CYCLE_LIMIT  = 50_000;
    localparam int PHASE_BYTES  = 180;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [3:0] {
        P_SCHEMA, P_KIND, P_CNT_HI, P_CNT_LO, P_FLAGS, P_ID,
        P_LEN0, P_LEN1, P_LEN2, P_LEN3, P_VALUE, P_DONE, P_DRAIN
    } parse_phase_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [3:0] st;
    } stim_row_t;

    // block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_field_id;
    logic        o_critical;
    logic [7:0]  o_value_byte;
    logic        o_field_end;
    logic [3:0]  o_status;
    logic        o_last_of_run;

    // parser model state and register copies
    parse_phase_e      ph;
    logic [BC_W-1:0]   rec_bytes;
    logic [15:0]       fields_left;
    logic [7:0]        prev_id;
    logic [7:0]        cur_id;
    logic              cur_crit;
    logic [31:0]       len_left;
    logic [3:0]        first_err;
    logic              pend_unknown;
    logic              hdr_bad;
    logic [7:0]        cfg_kind;
    logic [63:0]       cfg_known;

    t_result    expected_results [$];
    logic [7:0] rec_q [$];
    logic       pin_en = 1'b0;
    logic [3:0] pin_st = ST_OK;
    logic       idle_on = 1'b1;
    int         stall_left = 0;
    int         err_count = 0;
    int         cycles = 0;
    int         bytes_sent = 0;

    // directed records: min size, size over schema, schema, count cap,
    // and a critical field with an unknown id
    stim_row_t directed_rows [24] = '{
        '{SCHEMA_BYTE, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_SIZE},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_SCHEMA},
        '{SCHEMA_BYTE, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_COUNT},
        '{SCHEMA_BYTE, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{CRITICAL_BIT, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'hAB, 1'b1, 1'b1, ST_UNKNOWN}
    };

    tlv_record_validating_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_field_id    (o_field_id),
        .o_critical    (o_critical),
        .o_value_byte  (o_value_byte),
        .o_field_end   (o_field_end),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stalls in random bursts, which start only while idling is on
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < 40)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic clear_parser();
        ph           = P_SCHEMA;
        rec_bytes    = '0;
        fields_left  = '0;
        prev_id      = '0;
        cur_id       = '0;
        cur_crit     = 1'b0;
        len_left     = '0;
        first_err    = ST_OK;
        pend_unknown = 1'b0;
        hdr_bad      = 1'b0;
    endtask

    // append one item to the expected results
    task automatic add_expected(input t_result r);
        expected_results = {expected_results, r};
    endtask

    // append one byte to the record being built
    task automatic add_rec_byte(input logic [7:0] b);
        rec_q = {rec_q, b};
    endtask

    // first stream error is kept, the rest of the record is only counted
    task automatic raise_error(input logic [3:0] code);
        if (first_err == ST_OK)
            first_err = code;
        ph = P_DRAIN;
    endtask

    task automatic finish_field();
        if (pend_unknown) begin
            raise_error(ST_UNKNOWN);
        end else begin
            fields_left = fields_left - 16'd1;
            ph = (fields_left != 0) ? P_FLAGS : P_DONE;
        end
    endtask

    // model of one accepted byte: queues the items it causes
    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_result r;
        logic    known;
        int      s;
        r = '0;
        if (rec_bytes <= MAX_RECORD_BYTES)
            rec_bytes = rec_bytes + 1'b1;
        case (ph)
            P_SCHEMA: begin
                if (b != SCHEMA_BYTE) raise_error(ST_SCHEMA);
                else ph = P_KIND;
            end
            P_KIND: begin
                if (b != cfg_kind) raise_error(ST_SCHEMA);
                else ph = P_CNT_HI;
            end
            P_CNT_HI: begin
                fields_left = {b, 8'h00};
                ph = P_CNT_LO;
            end
            P_CNT_LO: begin
                fields_left[7:0] = b;
                if (fields_left > MAX_FIELDS) raise_error(ST_COUNT);
                else ph = (fields_left != 0) ? P_FLAGS : P_DONE;
            end
            P_FLAGS: begin
                cur_crit = b[0];
                hdr_bad  = (b & ~CRITICAL_BIT) != 8'h00;
                ph = P_ID;
            end
            P_ID: begin
                cur_id = b;
                if (b == 8'h00 || b <= prev_id)
                    hdr_bad = 1'b1;
                ph = P_LEN0;
            end
            P_LEN0: begin
                len_left = {24'd0, b};
                ph = P_LEN1;
            end
            P_LEN1, P_LEN2: begin
                len_left = {len_left[23:0], b};
                ph = (ph == P_LEN1) ? P_LEN2 : P_LEN3;
            end
            P_LEN3: begin
                len_left = {len_left[23:0], b};
                if (hdr_bad) begin
                    raise_error(ST_FLAGS);
                end else begin
                    // unknown-critical is judged against the registers now
                    prev_id = cur_id;
                    known = 1'b0;
                    for (s = 0; s < KNOWN_SLOTS; s++)
                        if (cfg_known[8*s +: 8] != 8'h00 && cfg_known[8*s +: 8] == cur_id)
                            known = 1'b1;
                    pend_unknown = cur_crit && !known;
                    if (len_left == 0) finish_field();
                    else ph = P_VALUE;
                end
            end
            P_VALUE: begin
                r.result_kind = KIND_VALUE;
                r.field_id    = cur_id;
                r.critical    = cur_crit;
                r.value_byte  = b;
                r.field_end   = (len_left == 32'd1);
                r.last_of_run = !last;
                add_expected(r);
                len_left = len_left - 32'd1;
                if (len_left == 0)
                    finish_field();
            end
            P_DONE: raise_error(ST_TRAILING);
            default: ;
        endcase
        if (last) begin
            // size beats every other check, then the first stream error; a pinned status overrides all
            r = '0;
            r.result_kind = KIND_STATUS;
            r.last_of_run = 1'b1;
            if (rec_bytes < 4 || rec_bytes > MAX_RECORD_BYTES) r.status = ST_SIZE;
            else if (first_err != ST_OK) r.status = first_err;
            else if (ph == P_DONE) r.status = ST_OK;
            else if (ph == P_VALUE) r.status = ST_TRUNC_VAL;
            else r.status = ST_TRUNC_HDR;
            if (pin_en)
                r.status = pin_st;
            add_expected(r);
            clear_parser();
        end
    endtask

    // accepted bytes are modelled first, then the output item is checked
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                predict_byte(i_data_byte, i_last_byte);
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("item with none expected", 8'(o_status), 8'h00);
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 8'(o_result_kind), 8'(want.result_kind));
                    check_field("field_id", o_field_id, want.field_id);
                    check_field("critical", 8'(o_critical), 8'(want.critical));
                    check_field("value_byte", o_value_byte, want.value_byte);
                    check_field("field_end", 8'(o_field_end), 8'(want.field_end));
                    check_field("status", 8'(o_status), 8'(want.status));
                    check_field("last_of_run", 8'(o_last_of_run), 8'(want.last_of_run));
                end
            end
        end
    end

    // one byte, with an optional gap before it; returns at the falling edge
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic pin, input logic [3:0] st);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        pin_en      = pin;
        pin_st      = st;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_record();
        int k;
        for (k = 0; k < rec_q.size(); k++)
            send_byte(rec_q[k], k == rec_q.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_EXPECTED_KIND) cfg_kind = val[7:0];
        else cfg_known = val;
    endtask

    // mostly well-formed records with random content, some noise and damage
    task automatic make_record();
        int          k;
        int          f;
        int          nfields;
        int          nvals;
        int          tmp;
        logic [15:0] cnt;
        logic [7:0]  prev;
        logic [7:0]  id;
        logic [31:0] len;
        rec_q.delete();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 12)) add_rec_byte(8'($urandom));
        end else begin
            add_rec_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : SCHEMA_BYTE);
            add_rec_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg_kind);
            k = $urandom_range(0, 29);
            if (k == 0) cnt = 16'($urandom);
            else if (k == 1) cnt = 16'(MAX_FIELDS);
            else if (k == 2) cnt = 16'(MAX_FIELDS + 1);
            else cnt = 16'($urandom_range(0, 4));
            add_rec_byte(cnt[15:8]);
            add_rec_byte(cnt[7:0]);
            nfields = (cnt > 6) ? $urandom_range(0, 3) : int'(cnt);
            prev = 8'h00;
            for (f = 0; f < nfields; f++) begin
                // flags: mostly only the critical bit
                add_rec_byte(($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 1)));
                // id: mostly rising, sometimes a known id, zero or a repeat
                k = $urandom_range(0, 19);
                if (k == 0) begin
                    id = 8'h00;
                end else if (k == 1) begin
                    id = prev;
                end else if (k < 8) begin
                    id = cfg_known[8*$urandom_range(0, 7) +: 8];
                end else begin
                    tmp = prev + 1 + $urandom_range(0, 39);
                    id = (tmp > 255) ? 8'hFF : 8'(tmp);
                end
                add_rec_byte(id);
                prev = id;
                // length: mostly short, sometimes longer, rarely huge
                k = $urandom_range(0, 29);
                if (k == 0) len = $urandom;
                else if (k < 4) len = $urandom_range(7, 40);
                else len = $urandom_range(0, 6);
                add_rec_byte(len[31:24]);
                add_rec_byte(len[23:16]);
                add_rec_byte(len[15:8]);
                add_rec_byte(len[7:0]);
                nvals = (len > 40) ? $urandom_range(0, 8) : int'(len);
                repeat (nvals) add_rec_byte(8'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) add_rec_byte(8'($urandom));
            if ($urandom_range(0, 9) == 0 && rec_q.size() > 1)
                rec_q = rec_q[0:$urandom_range(0, rec_q.size() - 2)];
        end
    endtask

    initial begin : stimulus
        int          p;
        int          r;
        int          s;
        int          target;
        logic [63:0] ids;
        cfg_kind  = '0;
        cfg_known = '0;
        clear_parser();

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed records with the registers at their reset values
        for (r = 0; r < $size(directed_rows); r++)
            send_byte(directed_rows[r].data, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].st);

        // random records under several register settings
        target = bytes_sent;
        for (p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: begin
                    write_reg(CFG_EXPECTED_KIND, 64'hFF);
                    write_reg(CFG_KNOWN_IDS, '1);
                end
                1, 2: begin
                    ids = '0;
                    for (s = 0; s < KNOWN_SLOTS; s++)
                        ids[8*s +: 8] = ($urandom_range(0, 2) == 0) ? 8'h00
                                                                    : 8'($urandom);
                    write_reg(CFG_EXPECTED_KIND, 64'($urandom_range(0, 255)));
                    write_reg(CFG_KNOWN_IDS, (p == 1) ? {$urandom, $urandom} : ids);
                end
                3: begin
                    write_reg(CFG_EXPECTED_KIND, '0);
                    write_reg(CFG_KNOWN_IDS, '0);
                end
                default: begin
                    write_reg(CFG_EXPECTED_KIND, {$urandom, $urandom});
                    write_reg(CFG_KNOWN_IDS, {$urandom, $urandom});
                end
            endcase
            target += PHASE_BYTES;
            while (bytes_sent < target) begin
                // last phase runs without any idling
                idle_on = (p < 4) && ($urandom_range(0, 4) != 0);
                make_record();
                send_record();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
